FILE: rtl/mfc_pkg.sv
// Shared types and constants for the 3x3 median filter core.
// No dependencies; imported by the top level, mfc_median9 and mfc_out_fifo.
`timescale 1ns / 1ps
package mfc_pkg;

    localparam int PIX_W      = 16;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 16'd3;

    // Result queue; the input side stalls once DEPTH-1 results are reserved.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [8:0][PIX_W-1:0] window_t;

    // Per-item bookkeeping that rides along the median pipeline.
    typedef struct packed {
        logic emit0;     // first result present
        logic emit1;     // second result (last column copy) present
        logic interior;  // first result is the median
        logic fe;        // first result closes the frame
        pix_t val0;      // copied value for the first result
        pix_t val1;      // value for the second result
    } meta_t;

    typedef struct packed {
        pix_t pixel;
        logic fe;
    } res_t;

endpackage

FILE: rtl/median_3x3_image_filter_core.sv
// Top level of the 3x3 median filter: stream control, window, line store, queue.
// Depends on mfc_pkg, mfc_line_store, mfc_median9 and mfc_out_fifo.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         s_axis_tvalid/tready      tdata = pixel_in, tuser = command
//  m_axis    out        m_axis_tvalid/tready      tdata = pixel_out, tlast = frame_end
//  cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data (always ready)
//
//  Throughput: one input transaction per cycle while s_axis_tready is high; the
//  line store is read when a transaction is accepted and written back in the
//  next cycle, so the RAM port pair sets the rate. The path to the result
//  queue is the RAM read, window shift and three median stages, plus queueing.
//  Reset: counters, window and queue clear synchronously; the line store has
//  no clearing pass, each entry is written before it is read.
//  Stalls: s_axis_tready drops while 15 or more results are reserved
//  (in flight or queued), so a full row-end pair always finds room.
//
module median_3x3_image_filter_core
    import mfc_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input pixel stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] pixel_in
    input  logic                 s_axis_tuser,   // [0] command
    // filtered pixel stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [15:0] pixel_out
    output logic                 m_axis_tlast,   // frame_end
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = ((WIDTH_W > IDX_W) ? WIDTH_W : IDX_W) + 1;

    // ---------------- configuration ----------------
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [IDX_W-1:0]    last_col;     // effective width minus one
    logic [HEIGHT_W-1:0] eff_height;
    logic [CMP_W-1:0]    width_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp width to 3..MAX_WIDTH and height to at least 3.
    always_comb begin
        width_ext = CMP_W'(width_reg);
        if (width_ext < CMP_W'(3)) begin
            last_col = IDX_W'(2);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            last_col = IDX_W'(MAX_WIDTH - 1);
        end else begin
            last_col = IDX_W'(width_ext - CMP_W'(1));
        end
        eff_height = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
    end

    // ---------------- accept stage ----------------
    logic [IDX_W-1:0]    col_reg;
    logic [IDX_W-1:0]    col_next;
    logic [HEIGHT_W-1:0] row_reg;
    logic [HEIGHT_W-1:0] row_next;
    logic [IDX_W-1:0]    drain_reg;
    logic [IDX_W-1:0]    drain_next;
    logic [PEND_W-1:0]   pend_reg;
    logic [PEND_W-1:0]   pend_next;

    logic             accept;
    logic             pix_take;
    logic             drain_take;
    logic             at_last_col;
    logic             at_last_drain;
    logic [IDX_W-1:0] xi;
    logic [IDX_W-1:0] di;
    logic [IDX_W-1:0] rd_addr;
    logic             emit0;
    logic             emit1;
    logic             interior;
    logic [1:0]       reserve;

    assign s_axis_tready = (pend_reg <= PEND_W'(FIFO_DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;
    // Drop pixels while a drain is pending and drains while none is.
    assign pix_take      = accept && (s_axis_tuser == CMD_PIXEL) && (row_reg < eff_height);
    assign drain_take    = accept && (s_axis_tuser == CMD_DRAIN) && (row_reg >= eff_height);

    always_comb begin
        at_last_col   = (col_reg >= last_col);
        at_last_drain = (drain_reg >= last_col);
        xi            = at_last_col ? last_col : col_reg;
        di            = at_last_drain ? last_col : drain_reg;
        rd_addr       = pix_take ? xi : di;

        if (drain_take) begin
            emit0    = 1'b1;
            emit1    = 1'b0;
            interior = 1'b0;
        end else begin
            emit0    = pix_take && (row_reg != '0) && (xi != '0);
            emit1    = emit0 && at_last_col;
            interior = (xi > IDX_W'(1)) && (row_reg > HEIGHT_W'(1));
        end
        reserve = {1'b0, emit0} + {1'b0, emit1};

        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (pix_take) begin
            if (at_last_col) begin
                col_next = '0;
                row_next = row_reg + HEIGHT_W'(1);
            end else begin
                col_next = col_reg + IDX_W'(1);
            end
        end else if (drain_take) begin
            if (at_last_drain) begin
                col_next   = '0;
                row_next   = '0;
                drain_next = '0;
            end else begin
                drain_next = drain_reg + IDX_W'(1);
            end
        end
    end

    // ---------------- stage 1: line store data arrives ----------------
    logic             s1_valid_reg;
    logic             s1_pix_reg;
    logic             s1_row0_reg;
    logic             s1_emit0_reg;
    logic             s1_emit1_reg;
    logic             s1_interior_reg;
    logic             s1_fe_reg;
    logic [IDX_W-1:0] s1_addr_reg;
    pix_t             s1_pixel_reg;
    logic             s1_fwd_reg;
    logic [31:0]      s1_fwd_data_reg;

    logic [31:0] rd_data;
    logic [31:0] line_word;
    logic [31:0] wr_data;
    logic        wr_en;

    // Bypass the RAM when the entry read now is the one being written back.
    assign wr_en     = s1_valid_reg && s1_pix_reg;
    assign line_word = s1_row0_reg ? '0 : (s1_fwd_reg ? s1_fwd_data_reg : rd_data);
    assign wr_data   = {line_word[15:0], s1_pixel_reg};

    mfc_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (IDX_W),
        .DATA_W (32)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (pix_take || drain_take),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            drain_reg    <= drain_next;
            pend_reg     <= pend_next;
            s1_valid_reg <= pix_take || drain_take;
        end
    end

    always_ff @(posedge aclk) begin
        s1_pix_reg      <= pix_take;
        s1_row0_reg     <= (row_reg == '0);
        s1_emit0_reg    <= emit0;
        s1_emit1_reg    <= emit1;
        s1_interior_reg <= interior;
        s1_fe_reg       <= drain_take && at_last_drain;
        s1_addr_reg     <= rd_addr;
        s1_pixel_reg    <= s_axis_tdata;
        s1_fwd_reg      <= wr_en && (s1_addr_reg == rd_addr);
        s1_fwd_data_reg <= wr_data;
    end

    // ---------------- window shift ----------------
    window_t window_reg;
    window_t window_next;
    logic    s2_valid_reg;
    meta_t   s2_meta_reg;
    meta_t   s1_meta;

    always_comb begin
        window_next = window_reg;
        if (wr_en) begin
            for (int r = 0; r < 3; r++) begin
                window_next[3*r]   = window_reg[3*r+1];
                window_next[3*r+1] = window_reg[3*r+2];
            end
            window_next[2] = line_word[31:16];
            window_next[5] = line_word[15:0];
            window_next[8] = s1_pixel_reg;
        end
        s1_meta.emit0    = s1_emit0_reg;
        s1_meta.emit1    = s1_emit1_reg;
        s1_meta.interior = s1_interior_reg;
        s1_meta.fe       = s1_fe_reg;
        s1_meta.val0     = s1_pix_reg ? window_next[4] : line_word[15:0];
        s1_meta.val1     = window_next[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            window_reg   <= window_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_meta_reg <= s1_meta;
    end

    // ---------------- median and result queue ----------------
    logic  med_valid;
    pix_t  med_value;
    meta_t med_meta;
    res_t  res0;
    res_t  res1;
    logic  push0;
    logic  push1;
    logic  pop;
    res_t  head;

    mfc_median9 u_median9 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s2_valid_reg),
        .in_window  (window_reg),
        .in_meta    (s2_meta_reg),
        .out_valid  (med_valid),
        .out_median (med_value),
        .out_meta   (med_meta)
    );

    always_comb begin
        push0      = med_valid && med_meta.emit0;
        push1      = med_valid && med_meta.emit1;
        res0.pixel = med_meta.interior ? med_value : med_meta.val0;
        res0.fe    = med_meta.fe;
        res1.pixel = med_meta.val1;
        res1.fe    = 1'b0;
    end

    mfc_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (push0),
        .data0     (res0),
        .push1     (push1),
        .data1     (res1),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_data  (head)
    );

    assign pop          = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = head.pixel;
    assign m_axis_tlast = head.fe;

    // Reserve result slots at accept, release them as transactions leave.
    assign pend_next = pend_reg + (accept ? PEND_W'(reserve) : '0) - PEND_W'(pop);

    // ---------------- checks ----------------
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PEND_W'(FIFO_DEPTH))
        else $error("result reservation exceeds queue depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg == '0) |-> !m_axis_tvalid)
        else $error("result offered with nothing reserved");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && s2_meta_reg.emit1 |-> s2_meta_reg.emit0)
        else $error("row-end copy without a first result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_fwd_reg |-> $past(wr_en))
        else $error("line store bypass without a pending write");

endmodule

FILE: rtl/mfc_line_store.sv
// Two-row line store: one synchronous RAM, registered read, one write port.
// Uses nothing from the package.
`timescale 1ns / 1ps
module mfc_line_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/mfc_median9.sv
// Three-stage median-of-nine pipeline (row sort, reduce, median of three).
// Depends on mfc_pkg for pixel, window and side-band types.
`timescale 1ns / 1ps
module mfc_median9
    import mfc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  window_t in_window,
    input  meta_t   in_meta,
    output logic    out_valid,
    output pix_t    out_median,
    output meta_t   out_meta
);

    typedef struct packed {
        pix_t hi;
        pix_t mid;
        pix_t lo;
    } sort3_t;

    function automatic sort3_t sort3(pix_t a, pix_t b, pix_t c);
        pix_t   lo1;
        pix_t   hi1;
        sort3_t r;
        lo1 = (a < b) ? a : b;
        hi1 = (a < b) ? b : a;
        if (c < lo1) begin
            r = '{hi: hi1, mid: lo1, lo: c};
        end else if (c < hi1) begin
            r = '{hi: hi1, mid: c, lo: lo1};
        end else begin
            r = '{hi: c, mid: hi1, lo: lo1};
        end
        return r;
    endfunction

    sort3_t     row_reg [3];
    pix_t       max_lo_reg;
    pix_t       mid_mid_reg;
    pix_t       min_hi_reg;
    pix_t       median_reg;
    logic [2:0] valid_reg;
    meta_t      meta_reg [3];
    sort3_t     lo_sort;
    sort3_t     mid_sort;
    sort3_t     hi_sort;
    sort3_t     fin_sort;

    always_comb begin
        lo_sort  = sort3(row_reg[0].lo,  row_reg[1].lo,  row_reg[2].lo);
        mid_sort = sort3(row_reg[0].mid, row_reg[1].mid, row_reg[2].mid);
        hi_sort  = sort3(row_reg[0].hi,  row_reg[1].hi,  row_reg[2].hi);
        fin_sort = sort3(max_lo_reg, mid_mid_reg, min_hi_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        for (int r = 0; r < 3; r++) begin
            row_reg[r] <= sort3(in_window[3*r], in_window[3*r+1], in_window[3*r+2]);
        end
        max_lo_reg  <= lo_sort.hi;
        mid_mid_reg <= mid_sort.mid;
        min_hi_reg  <= hi_sort.lo;
        median_reg  <= fin_sort.mid;
        meta_reg[0] <= in_meta;
        meta_reg[1] <= meta_reg[0];
        meta_reg[2] <= meta_reg[1];
    end

    assign out_valid  = valid_reg[2];
    assign out_median = median_reg;
    assign out_meta   = meta_reg[2];

endmodule

FILE: rtl/mfc_out_fifo.sv
// Result queue: up to two pushes and one pop per cycle.
// Depends on mfc_pkg for the result type and queue depth.
`timescale 1ns / 1ps
module mfc_out_fifo
    import mfc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push0,
    input  res_t data0,
    input  logic push1,
    input  res_t data1,
    input  logic pop,
    output logic out_valid,
    output res_t out_data
);

    res_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg;
    logic [FIFO_AW-1:0] rptr_reg;
    logic [PEND_W-1:0]  count_reg;
    logic [PEND_W-1:0]  count_next;
    logic [FIFO_AW-1:0] wptr_next;
    logic [1:0]         n_push;

    assign n_push = {1'b0, push0} + {1'b0, push1};

    always_comb begin
        wptr_next  = wptr_reg + FIFO_AW'(n_push);
        count_next = count_reg + PEND_W'(n_push) - PEND_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            count_reg <= count_next;
            if (pop) begin
                rptr_reg <= rptr_reg + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            mem_reg[wptr_reg] <= data0;
        end
        if (push1) begin
            mem_reg[wptr_reg + FIFO_AW'(1)] <= data1;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rptr_reg];

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PEND_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push1 |-> push0)
        else $error("second result pushed without the first");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> out_valid)
        else $error("pop from empty result queue");

endmodule
